FILE: hw/rtl/div64_pkg.sv
// Shared commands, stage record and latency for the 64-bit divider.
package div64_pkg;

  localparam int unsigned DataWidth = 64;
  // One operand-conditioning stage, one stage per quotient bit, one result stage.
  localparam int unsigned DivLatency = DataWidth + 2;

  typedef enum logic [1:0] {
    CMD_UQUO = 2'd0,
    CMD_UREM = 2'd1,
    CMD_SQUO = 2'd2,
    CMD_SREM = 2'd3
  } div_cmd_t;

  // Data that travels down the step chain with each transaction.
  typedef struct packed {
    logic                 is_rem;  // deliver the remainder, not the quotient
    logic                 neg;     // negate the delivered value
    logic                 dz;      // divisor is zero
    logic [DataWidth-1:0] den;     // divisor magnitude
    logic [DataWidth-1:0] rem;     // partial remainder
    logic [DataWidth-1:0] quo;     // unused dividend bits shifting out, quotient bits in
  } div_stage_t;

endpackage

FILE: hw/rtl/divider_64bit_signed_unsigned.sv
// Pipelined 64-bit signed/unsigned restoring divider, top level.
//
//   channel   ports                              handshake
//   -------   --------------------------------   ----------------------------------
//   request   command, dividend, divisor         taken when start && !busy
//   response  result                             one-cycle strobe on done, no stall
//
// A transaction passes through the stages in order: one stage
// takes operand magnitudes, 64 stages each settle one quotient bit with a
// 65-bit subtract, and one stage selects, negates and zeroes the result.
// A new transaction may start every cycle; busy is high only during reset.
// Synchronous reset clears the valid bits; payload registers are not reset.
module divider_64bit_signed_unsigned (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  div64_pkg::div_cmd_t                command,
  input  logic [div64_pkg::DataWidth-1:0]    dividend,
  input  logic [div64_pkg::DataWidth-1:0]    divisor,
  output logic                               done,
  output logic [div64_pkg::DataWidth-1:0]    result
);
  import div64_pkg::*;

  localparam int unsigned Steps = DataWidth;

  logic [Steps:0] vld;
  div_stage_t     pipe [0:Steps];

  logic                 accept;
  logic                 is_signed;
  logic [DataWidth-1:0] a_mag;
  logic [DataWidth-1:0] b_mag;
  logic [DataWidth-1:0] sel_val;
  logic [DataWidth-1:0] res_next;

  // One restoring step: shift in the next dividend bit, try the subtract.
  function automatic div_stage_t div_step(input div_stage_t s);
    logic [DataWidth:0] shifted;
    logic [DataWidth:0] diff;
    div_stage_t         n;
    shifted = {s.rem, s.quo[DataWidth-1]};
    diff    = shifted - {1'b0, s.den};
    n       = s;
    if (!diff[DataWidth]) begin
      n.rem = diff[DataWidth-1:0];
      n.quo = {s.quo[DataWidth-2:0], 1'b1};
    end else begin
      n.rem = shifted[DataWidth-1:0];
      n.quo = {s.quo[DataWidth-2:0], 1'b0};
    end
    return n;
  endfunction

  assign busy      = rst;
  assign accept    = start && !busy;
  assign is_signed = (command == CMD_SQUO) || (command == CMD_SREM);
  assign a_mag     = (is_signed && dividend[DataWidth-1]) ? (DataWidth'(0) - dividend) : dividend;
  assign b_mag     = (is_signed && divisor[DataWidth-1])  ? (DataWidth'(0) - divisor)  : divisor;

  // Operand conditioning stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pipe[0].is_rem <= (command == CMD_UREM) || (command == CMD_SREM);
    pipe[0].neg    <= (command == CMD_SQUO) ? (dividend[DataWidth-1] ^ divisor[DataWidth-1])
                    : (command == CMD_SREM) ? dividend[DataWidth-1]
                    : 1'b0;
    pipe[0].dz     <= (divisor == '0);
    pipe[0].den    <= b_mag;
    pipe[0].rem    <= '0;
    pipe[0].quo    <= a_mag;
  end

  // Step chain, one quotient bit per stage, most significant first.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      pipe[i+1] <= div_step(pipe[i]);
    end
  end

  // Result stage: pick, fix the sign, force zero on a zero divisor.
  assign sel_val  = pipe[Steps].is_rem ? pipe[Steps].rem : pipe[Steps].quo;
  assign res_next = pipe[Steps].dz  ? '0
                  : pipe[Steps].neg ? (DataWidth'(0) - sel_val)
                  : sel_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[Steps];
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

FILE: hw/rtl/div64_checker.sv
// Port-level checks for the divider, bound to the top level.
module div64_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input div64_pkg::div_cmd_t             command,
  input logic [div64_pkg::DataWidth-1:0] dividend,
  input logic [div64_pkg::DataWidth-1:0] divisor,
  input logic                            done,
  input logic [div64_pkg::DataWidth-1:0] result
);
  import div64_pkg::*;

  // Every accepted transaction is followed by a done strobe.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##DivLatency done)
    else $error("transaction not completed at fixed latency");

  // No result without a matching transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, DivLatency))
    else $error("result strobe without a transaction");

  // Zero divisor gives zero.
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && divisor == '0) |-> ##DivLatency (result == '0))
    else $error("nonzero result for zero divisor");

  // Unsigned divide by one returns the dividend.
  a_div_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_UQUO && divisor == DataWidth'(1))
      |-> ##DivLatency (result == $past(dividend, DivLatency)))
    else $error("divide by one does not return the dividend");

  // Unsigned remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_UREM && divisor != '0)
      |-> ##DivLatency (result < $past(divisor, DivLatency)))
    else $error("remainder not below divisor");

endmodule

bind divider_64bit_signed_unsigned div64_checker u_div64_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .command  (command),
  .dividend (dividend),
  .divisor  (divisor),
  .done     (done),
  .result   (result)
);

FILE: tb/divider_64bit_signed_unsigned_checker.sv
// Checker for the 64-bit divider: predicts each division and compares the results.
module divider_64bit_signed_unsigned_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  div64_pkg::div_cmd_t             command,
  input  logic [div64_pkg::DataWidth-1:0] dividend,
  input  logic [div64_pkg::DataWidth-1:0] divisor,
  input  logic                            done,
  input  logic [div64_pkg::DataWidth-1:0] result,
  output int unsigned                     failures,
  output int unsigned                     pending
);
  import div64_pkg::*;

  logic [DataWidth-1:0] awaited_results[$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic logic [DataWidth-1:0] compute_division(
    div_cmd_t             cmd,
    logic [DataWidth-1:0] num,
    logic [DataWidth-1:0] den
  );
    logic                 num_neg;
    logic                 den_neg;
    logic [DataWidth-1:0] num_mag;
    logic [DataWidth-1:0] den_mag;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] rem;
    if (den == '0) return '0;
    num_neg = num[DataWidth-1];
    den_neg = den[DataWidth-1];
    if (cmd == CMD_UQUO || cmd == CMD_UREM) begin
      num_mag = num;
      den_mag = den;
    end else begin
      // The most negative pattern keeps 2^63 as its unsigned magnitude.
      num_mag = num_neg ? '0 - num : num;
      den_mag = den_neg ? '0 - den : den;
    end
    quo = num_mag / den_mag;
    rem = num_mag % den_mag;
    case (cmd)
      CMD_UQUO: return quo;
      CMD_UREM: return rem;
      CMD_SQUO: return (num_neg != den_neg) ? '0 - quo : quo;
      default:  return num_neg ? '0 - rem : rem;
    endcase
  endfunction

  always @(posedge clk) begin : watch_channels
    logic [DataWidth-1:0] want;
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, result);
          failures <= failures + 1;
        end else begin
          want = awaited_results.pop_front();
          if (result !== want) begin
            $display("%0t: result mismatch: expected %h, actual %h", $time, want, result);
            failures <= failures + 1;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(compute_division(command, dividend, divisor));
      pending <= awaited_results.size();
    end
  end

endmodule

FILE: tb/divider_64bit_signed_unsigned_test.sv
// Testbench top for the 64-bit divider: stimulus, watchdog and verdict.
module divider_64bit_signed_unsigned_test;
  import div64_pkg::*;

  localparam int unsigned RandomDivisions = 650;
  localparam int unsigned MaxGap          = 13;
  localparam int unsigned WatchdogLimit   = 1000;

  localparam logic [DataWidth-1:0] AllOnes  = '1;
  localparam logic [DataWidth-1:0] MostNeg  = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] MostPos  = {1'b0, {(DataWidth-1){1'b1}}};

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 start    = 1'b0;
  div_cmd_t             command  = CMD_UQUO;
  logic [DataWidth-1:0] dividend = '0;
  logic [DataWidth-1:0] divisor  = '0;
  logic                 busy;
  logic                 done;
  logic [DataWidth-1:0] result;
  int unsigned          failures;
  int unsigned          pending;
  int unsigned          idle_cycles = 0;

  divider_64bit_signed_unsigned u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .result   (result)
  );

  divider_64bit_signed_unsigned_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .result   (result),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Issue one division transaction and return at the edge that takes it.
  task automatic issue_division(div_cmd_t cmd, logic [DataWidth-1:0] num,
                                logic [DataWidth-1:0] den);
    int unsigned gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    command  <= cmd;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [DataWidth-1:0] pick_operand();
    logic [DataWidth-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return full;
      4, 5:       return full >> $urandom_range(0, DataWidth - 1);
      6:          return '0 - (full >> $urandom_range(0, DataWidth - 1));
      7:          return DataWidth'($urandom_range(0, 15));
      8:          return '0 - DataWidth'($urandom_range(1, 15));
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return DataWidth'(1);
          2:       return AllOnes;
          3:       return MostNeg;
          default: return MostPos;
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [DataWidth-1:0] nums[6];
    logic [DataWidth-1:0] dens[6];
    div_cmd_t             cmd;
    logic [DataWidth-1:0] den;
    // Overflow wrap, zero divisor, identity, sign mixes, divisor above 2^63.
    nums = '{MostNeg, AllOnes, AllOnes, '0 - DataWidth'(7), DataWidth'(7), AllOnes - 1};
    dens = '{AllOnes, '0, DataWidth'(1), DataWidth'(2), '0 - DataWidth'(2), AllOnes};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (nums[i]) begin
      cmd = cmd.first();
      repeat (4) begin
        issue_division(cmd, nums[i], dens[i]);
        cmd = cmd.next();
      end
    end
    repeat (RandomDivisions) begin
      cmd = div_cmd_t'($urandom_range(0, 3));
      den = ($urandom_range(0, 19) == 0) ? '0 : pick_operand();
      issue_division(cmd, pick_operand(), den);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Catch any stray result still in the pipe.
    repeat (DivLatency + 4) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
